/* rtl/barometric_sensor_compensation_defines.svh */
// Assertion macros shared by the RTL
`ifndef BAROMETRIC_SENSOR_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define BSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define BSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bsc_pkg.sv */
`default_nettype none
package bsc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_AC1     = 3'd0;
    localparam logic [2:0] REG_AC2     = 3'd1;
    localparam logic [2:0] REG_AC3     = 3'd2;
    localparam logic [2:0] REG_AC4     = 3'd3;
    localparam logic [2:0] REG_AC5_AC6 = 3'd4;
    localparam logic [2:0] REG_B1      = 3'd5;
    localparam logic [2:0] REG_B2      = 3'd6;
    localparam logic [2:0] REG_MC_MD   = 3'd7;

    localparam int CFG_IDX_W = 4;

    // datasheet constants
    localparam logic [31:0] B6_OFFSET = 32'd4000;
    localparam logic [31:0] B4_BIAS   = 32'd32768;
    localparam logic [31:0] B7_SCALE  = 32'd50000;
    localparam logic [31:0] P_K1      = 32'd3038;
    localparam logic [31:0] P_K2      = 32'd7357;
    localparam logic [31:0] P_K3      = 32'd3791;

    // divider depth: one quotient bit per stage
    localparam int DIV_W = 32;

endpackage
`default_nettype wire

/* rtl/barometric_sensor_compensation.sv */
`default_nettype none
// Barometric temperature/pressure compensation, oversampling 0.
// Input channel s_*: one raw temperature and one raw pressure word per
// transfer. Result channel m_*: temperature in 0.1 C, pressure in Pa and
// a divide error flag (results zero when a divisor is zero).
// Configuration channel cfg_*: register index and write data; write the
// calibration words only while no item is in flight.
// The path from input transfer to result valid runs through the two
// 32-stage bit-per-stage divider pipelines (temperature quotient and
// pressure quotient), the multiplier stages around them and the output register.
// Throughput: one item per cycle while results are taken. The pipe is one stall domain: when the
// receiver holds m_ready low with a result waiting, every stage freezes,
// s_ready drops, nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and the
// calibration registers to zero. cfg_ready is always high.
module barometric_sensor_compensation (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_raw_temp,
    input  wire logic [15:0] s_raw_press,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_temp_tenths,
    output logic [31:0]      m_press_pa,
    output logic             m_div_error,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);
`include "barometric_sensor_compensation_defines.svh"

    // ---------------- configuration registers ----------------
    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg, b1_reg, b2_reg;
    logic [31:0] ac56_reg, mcmd_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ac1_reg <= '0; ac2_reg <= '0; ac3_reg <= '0; ac4_reg <= '0;
            b1_reg <= '0; b2_reg <= '0; ac56_reg <= '0; mcmd_reg <= '0;
        end else if (cfg_valid && cfg_index[3] == 1'b0) begin
            case (cfg_index[2:0])
                bsc_pkg::REG_AC1:     ac1_reg  <= cfg_data[15:0];
                bsc_pkg::REG_AC2:     ac2_reg  <= cfg_data[15:0];
                bsc_pkg::REG_AC3:     ac3_reg  <= cfg_data[15:0];
                bsc_pkg::REG_AC4:     ac4_reg  <= cfg_data[15:0];
                bsc_pkg::REG_AC5_AC6: ac56_reg <= cfg_data;
                bsc_pkg::REG_B1:      b1_reg   <= cfg_data[15:0];
                bsc_pkg::REG_B2:      b2_reg   <= cfg_data[15:0];
                bsc_pkg::REG_MC_MD:   mcmd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = {{16{ac1_reg[15]}}, ac1_reg};
    assign ac2 = {{16{ac2_reg[15]}}, ac2_reg};
    assign ac3 = {{16{ac3_reg[15]}}, ac3_reg};
    assign ac4 = {16'd0, ac4_reg};
    assign ac5 = {16'd0, ac56_reg[31:16]};
    assign ac6 = {16'd0, ac56_reg[15:0]};
    assign b1  = {{16{b1_reg[15]}}, b1_reg};
    assign b2  = {{16{b2_reg[15]}}, b2_reg};
    assign mc  = {{16{mcmd_reg[31]}}, mcmd_reg[31:16]};
    assign md  = {{16{mcmd_reg[15]}}, mcmd_reg[15:0]};

    // global stall: the pipe advances unless a result waits untaken
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------- stage 1: (ut - ac6) * ac5 ----------------
    logic        v1_reg;
    logic [31:0] t1_prod_reg;
    logic [15:0] up1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= s_valid;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            t1_prod_reg <= ({16'd0, s_raw_temp} - ac6) * ac5;
            up1_reg     <= s_raw_press;
        end
    end

    // ---------------- stage 2: x1, den, sign-magnitude split ----------------
    logic [31:0] x1_t, den2, num2;
    assign x1_t = $signed(t1_prod_reg) >>> 15;
    assign den2 = x1_t + md;
    assign num2 = mc << 11;

    logic        v2_reg, zt2_reg, neg2_reg;
    logic [31:0] x1t2_reg, nabs2_reg, dabs2_reg;
    logic [15:0] up2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en)  v2_reg <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            x1t2_reg  <= x1_t;
            zt2_reg   <= (den2 == 32'd0);
            neg2_reg  <= num2[31] ^ den2[31];
            nabs2_reg <= num2[31] ? (32'd0 - num2) : num2;
            dabs2_reg <= (den2 == 32'd0) ? 32'd1 :
                         (den2[31] ? (32'd0 - den2) : den2);
            up2_reg   <= up1_reg;
        end
    end

    // ---------------- temperature divider ----------------
    localparam int SB1_W = 32 + 16 + 2;
    logic                      dv1_valid;
    logic [bsc_pkg::DIV_W-1:0] dv1_quo;
    logic [SB1_W-1:0]          dv1_sb;
    bsc_udiv #(.W(bsc_pkg::DIV_W), .SB_W(SB1_W)) u_div_t (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v2_reg), .in_num(nabs2_reg[bsc_pkg::DIV_W-1:0]),
        .in_den(dabs2_reg[bsc_pkg::DIV_W-1:0]),
        .in_sb({x1t2_reg, up2_reg, zt2_reg, neg2_reg}),
        .out_valid(dv1_valid), .out_quo(dv1_quo), .out_sb(dv1_sb)
    );

    // ---------------- stage 3: b5, t, b6 ----------------
    logic [31:0] q3, b5_3;
    assign q3   = dv1_sb[0] ? (32'd0 - 32'(dv1_quo)) : 32'(dv1_quo);
    assign b5_3 = dv1_sb[49:18] + q3;

    logic        v3_reg, err3_reg;
    logic [31:0] t3_reg, b6_3_reg;
    logic [15:0] up3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en)  v3_reg <= dv1_valid;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            err3_reg <= dv1_sb[1];
            t3_reg   <= $signed(b5_3 + 32'd8) >>> 4;
            b6_3_reg <= b5_3 - bsc_pkg::B6_OFFSET;
            up3_reg  <= dv1_sb[17:2];
        end
    end

    // ---------------- stage 4: b6*b6, ac2*b6, ac3*b6 ----------------
    logic        v4_reg, err4_reg;
    logic [31:0] t4_reg, sqp4_reg, a2b6_4_reg, a3b6_4_reg;
    logic [15:0] up4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en)  v4_reg <= v3_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            err4_reg   <= err3_reg;
            t4_reg     <= t3_reg;
            up4_reg    <= up3_reg;
            sqp4_reg   <= b6_3_reg * b6_3_reg;
            a2b6_4_reg <= ac2 * b6_3_reg;
            a3b6_4_reg <= ac3 * b6_3_reg;
        end
    end

    // ---------------- stage 5: b2*sq, b1*sq ----------------
    logic [31:0] sq5;
    assign sq5 = $signed(sqp4_reg) >>> 12;
    logic        v5_reg, err5_reg;
    logic [31:0] t5_reg, b2sq5_reg, b1sq5_reg, x2b3_5_reg, x1b4_5_reg;
    logic [15:0] up5_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (en)  v5_reg <= v4_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            err5_reg   <= err4_reg;
            t5_reg     <= t4_reg;
            up5_reg    <= up4_reg;
            b2sq5_reg  <= b2 * sq5;
            b1sq5_reg  <= b1 * sq5;
            x2b3_5_reg <= $signed(a2b6_4_reg) >>> 11;
            x1b4_5_reg <= $signed(a3b6_4_reg) >>> 13;
        end
    end

    // ---------------- stage 6: b3, x3 ----------------
    // shifts kept in their own signals so they stay arithmetic
    logic [31:0] b2sq_s, b1sq_s, b3s, b3q, x3p, x3_6;
    assign b2sq_s = $signed(b2sq5_reg) >>> 11;
    assign b1sq_s = $signed(b1sq5_reg) >>> 16;
    assign b3s  = ac1 * 32'd4 + (b2sq_s + x2b3_5_reg) + 32'd2;
    // truncating divide by 4: bias negatives by 3 before the shift
    assign b3q  = $signed(b3s + (b3s[31] ? 32'd3 : 32'd0)) >>> 2;
    assign x3p  = x1b4_5_reg + b1sq_s + 32'd2;
    assign x3_6 = $signed(x3p) >>> 2;

    logic        v6_reg, err6_reg;
    logic [31:0] t6_reg, b3_6_reg, x3b_6_reg;
    logic [15:0] up6_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (en)  v6_reg <= v5_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            err6_reg  <= err5_reg;
            t6_reg    <= t5_reg;
            up6_reg   <= up5_reg;
            b3_6_reg  <= b3q;
            x3b_6_reg <= x3_6 + bsc_pkg::B4_BIAS;
        end
    end

    // ---------------- stage 7: ac4 * (x3+32768), (up - b3) * 50000 ----------------
    logic        v7_reg, err7_reg;
    logic [31:0] t7_reg, b4p7_reg, b7_7_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v7_reg <= 1'b0;
        else if (en)  v7_reg <= v6_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            err7_reg <= err6_reg;
            t7_reg   <= t6_reg;
            b4p7_reg <= ac4 * x3b_6_reg;
            b7_7_reg <= ({16'd0, up6_reg} - b3_6_reg) * bsc_pkg::B7_SCALE;
        end
    end

    // ---------------- stage 8: divider operands ----------------
    logic [31:0] b4_8;
    assign b4_8 = b4p7_reg >> 15;
    logic        v8_reg, err8_reg, hi8_reg;
    logic [31:0] t8_reg, num8_reg, den8_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v8_reg <= 1'b0;
        else if (en)  v8_reg <= v7_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            err8_reg <= err7_reg || (b4_8 == 32'd0);
            t8_reg   <= t7_reg;
            hi8_reg  <= b7_7_reg[31];
            num8_reg <= b7_7_reg[31] ? b7_7_reg : (b7_7_reg << 1);
            den8_reg <= (b4_8 == 32'd0) ? 32'd1 : b4_8;
        end
    end

    // ---------------- pressure divider ----------------
    localparam int SB2_W = 32 + 2;
    logic                      dv2_valid;
    logic [bsc_pkg::DIV_W-1:0] dv2_quo;
    logic [SB2_W-1:0]          dv2_sb;
    bsc_udiv #(.W(bsc_pkg::DIV_W), .SB_W(SB2_W)) u_div_p (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v8_reg), .in_num(num8_reg[bsc_pkg::DIV_W-1:0]),
        .in_den(den8_reg[bsc_pkg::DIV_W-1:0]),
        .in_sb({t8_reg, err8_reg, hi8_reg}),
        .out_valid(dv2_valid), .out_quo(dv2_quo), .out_sb(dv2_sb)
    );

    // ---------------- stage 9: p, p>>8 ----------------
    logic [31:0] p9;
    assign p9 = dv2_sb[0] ? (32'(dv2_quo) << 1) : 32'(dv2_quo);
    logic        v9_reg, err9_reg;
    logic [31:0] t9_reg, p9_reg, ps9_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v9_reg <= 1'b0;
        else if (en)  v9_reg <= dv2_valid;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            err9_reg <= dv2_sb[1];
            t9_reg   <= dv2_sb[33:2];
            p9_reg   <= p9;
            ps9_reg  <= $signed(p9) >>> 8;
        end
    end

    // ---------------- stage 10: (p>>8)^2, 7357*p ----------------
    logic        v10_reg, err10_reg;
    logic [31:0] t10_reg, p10_reg, sqp10_reg, k2p10_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v10_reg <= 1'b0;
        else if (en)  v10_reg <= v9_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            err10_reg <= err9_reg;
            t10_reg   <= t9_reg;
            p10_reg   <= p9_reg;
            sqp10_reg <= ps9_reg * ps9_reg;
            k2p10_reg <= bsc_pkg::P_K2 * p9_reg;
        end
    end

    // ---------------- stage 11: x1 * 3038 ----------------
    logic        v11_reg, err11_reg;
    logic [31:0] t11_reg, p11_reg, k1_11_reg, x2_11_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v11_reg <= 1'b0;
        else if (en)  v11_reg <= v10_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            err11_reg <= err10_reg;
            t11_reg   <= t10_reg;
            p11_reg   <= p10_reg;
            k1_11_reg <= sqp10_reg * bsc_pkg::P_K1;
            x2_11_reg <= $signed(32'd0 - k2p10_reg) >>> 16;
        end
    end

    // ---------------- output register ----------------
    logic [31:0] k1s, pcorr, pshift, pfin;
    assign k1s    = $signed(k1_11_reg) >>> 16;
    assign pcorr  = k1s + x2_11_reg + bsc_pkg::P_K3;
    assign pshift = $signed(pcorr) >>> 4;
    assign pfin   = p11_reg + pshift;

    logic        m_valid_reg, m_err_reg;
    logic [31:0] m_t_reg, m_p_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (en)  m_valid_reg <= v11_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            m_err_reg <= err11_reg;
            m_t_reg   <= err11_reg ? 32'd0 : t11_reg;
            m_p_reg   <= err11_reg ? 32'd0 : pfin;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_temp_tenths = m_t_reg;
    assign m_press_pa    = m_p_reg;
    assign m_div_error   = m_err_reg;

    // ---------------- assertions ----------------
    `BSC_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_press_pa) && $stable(m_temp_tenths), "result changed under stall")
    `BSC_ASSERT_IMPL(a_err_zero, aclk, aresetn, m_valid && m_div_error,
        m_press_pa == 32'd0 && m_temp_tenths == 32'd0, "error result not zero")
    `BSC_ASSERT_IMPL(a_ready_stall, aclk, aresetn, m_valid && !m_ready,
        !s_ready, "input taken while pipe stalled")

endmodule
`default_nettype wire

/* rtl/bsc_udiv.sv */
`default_nettype none
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Sideband payload travels alongside. Stall freezes the whole pipe.
module bsc_udiv #(
    parameter int W    = bsc_pkg::DIV_W,
    parameter int SB_W = 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [W-1:0]    in_num,
    input  wire logic [W-1:0]    in_den,
    input  wire logic [SB_W-1:0] in_sb,
    output logic                 out_valid,
    output logic [W-1:0]         out_quo,
    output logic [SB_W-1:0]      out_sb
);

    logic            vld_reg [1:W];
    logic [W-1:0]    rem_reg [1:W];
    logic [W-1:0]    num_reg [1:W];
    logic [W-1:0]    den_reg [1:W];
    logic [SB_W-1:0] sb_reg  [1:W];

    // one restoring step per stage; num_reg shifts quotient bits in
    for (genvar i = 0; i < W; i++) begin : g_stage
        logic            vld_in;
        logic [W-1:0]    rem_in;
        logic [W-1:0]    num_in;
        logic [W-1:0]    den_in;
        logic [SB_W-1:0] sb_in;
        logic [W:0]      trial;
        logic [W:0]      diff;

        // first stage takes the new operands, the rest the stage before
        if (i == 0) begin : g_first
            assign vld_in = in_valid;
            assign rem_in = '0;
            assign num_in = in_num;
            assign den_in = in_den;
            assign sb_in  = in_sb;
        end else begin : g_next
            assign vld_in = vld_reg[i];
            assign rem_in = rem_reg[i];
            assign num_in = num_reg[i];
            assign den_in = den_reg[i];
            assign sb_in  = sb_reg[i];
        end

        assign trial = {rem_in, num_in[W-1]};
        assign diff  = trial - {1'b0, den_in};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_in;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!diff[W]) begin
                    rem_reg[i+1] <= diff[W-1:0];
                    num_reg[i+1] <= {num_in[W-2:0], 1'b1};
                end else begin
                    rem_reg[i+1] <= trial[W-1:0];
                    num_reg[i+1] <= {num_in[W-2:0], 1'b0};
                end
                den_reg[i+1] <= den_in;
                sb_reg[i+1]  <= sb_in;
            end
        end
    end

    assign out_valid = vld_reg[W];
    assign out_quo   = num_reg[W];
    assign out_sb    = sb_reg[W];

endmodule
`default_nettype wire
